>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CASHA_CHECK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CASHA_CHECK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/casha_pkg.sv
package casha_pkg;

  localparam logic [39:0] GEN0 = 40'h98f2bc8e61;
  localparam logic [39:0] GEN1 = 40'h79b76d99e2;
  localparam logic [39:0] GEN2 = 40'hf33e5fb3c4;
  localparam logic [39:0] GEN3 = 40'hae2eabe2a8;
  localparam logic [39:0] GEN4 = 40'h1e4f43e470;

  localparam logic [255:0] SYM_STR  = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  localparam logic [95:0]  MAIN_PFX = "bitcoincash:";
  localparam logic [63:0]  TEST_PFX = "bchtest:";

  localparam logic [3:0] MAIN_PFX_LAST = 4'd11;
  localparam logic [3:0] TEST_PFX_LAST = 4'd7;

  // configuration register indexes
  localparam logic [1:0] REG_TEST_NETWORK = 2'd0;
  localparam logic [1:0] REG_ADDRESS_TYPE = 2'd1;
  localparam logic [1:0] REG_EMIT_PREFIX  = 2'd2;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first;
    logic       last;
    logic       test_network;
    logic [4:0] address_type;
    logic       emit_prefix;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREFIX,
    B_SYM,
    B_PAD,
    B_ABSORB,
    B_CSUM
  } back_state_t;

  function automatic logic [39:0] poly_step(logic [39:0] c, logic [4:0] d);
    logic [4:0]  top;
    logic [39:0] r;
    top = c[39:35];
    r   = {c[34:0], d};
    if (top[0]) r = r ^ GEN0;
    if (top[1]) r = r ^ GEN1;
    if (top[2]) r = r ^ GEN2;
    if (top[3]) r = r ^ GEN3;
    if (top[4]) r = r ^ GEN4;
    return r;
  endfunction

  // checksum after the prefix letters and the zero separator
  function automatic logic [39:0] prefix_start(logic testnet);
    logic [39:0] c;
    c = 40'd1;
    if (testnet) begin
      for (int i = 0; i < 7; i++) begin
        c = poly_step(c, TEST_PFX[8*(7-i) +: 5]);
      end
    end else begin
      for (int i = 0; i < 11; i++) begin
        c = poly_step(c, MAIN_PFX[8*(11-i) +: 5]);
      end
    end
    c = poly_step(c, 5'd0);
    return c;
  endfunction

  localparam logic [39:0] MAIN_START = prefix_start(1'b0);
  localparam logic [39:0] TEST_START = prefix_start(1'b1);

  function automatic logic [6:0] sym_char(logic [4:0] s);
    return SYM_STR[{5'(5'd31 - s), 3'b000} +: 7];
  endfunction

  function automatic logic [6:0] pfx_char(logic testnet, logic [3:0] idx);
    logic [6:0] ch;
    if (testnet) ch = TEST_PFX[{3'(3'd7 - idx[2:0]), 3'b000} +: 7];
    else         ch = MAIN_PFX[{4'(4'd11 - idx), 3'b000} +: 7];
    return ch;
  endfunction

endpackage

>>> rtl/casha_ifs.sv
interface casha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;

  modport source (output valid, output payload_byte, input ready);
  modport sink   (input valid, input payload_byte, output ready);
endinterface

interface casha_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] addr_char;
  logic       last_char;

  modport source (output valid, output addr_char, output last_char, input ready);
  modport sink   (input valid, input addr_char, input last_char, output ready);
endinterface

>>> rtl/casha_front.sv
module casha_front #(
  parameter int PAYLOAD_BYTES = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  casha_in_if.sink            in_ch,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_wdata,
  input  casha_pkg::fifo_stat_t q_stat,
  output logic                q_push,
  output casha_pkg::entry_t   q_entry
);

  localparam int CW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CW-1:0] LAST_CNT = CW'(PAYLOAD_BYTES - 1);

  logic          test_r, test_nxt;
  logic [4:0]    type_r, type_nxt;
  logic          emit_r, emit_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          is_last;

  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && !q_stat.full;
  assign is_last     = (cnt_r == LAST_CNT);

  always_comb begin
    q_entry.payload_byte = in_ch.payload_byte;
    q_entry.first        = (cnt_r == '0);
    q_entry.last         = is_last;
    q_entry.test_network = test_r;
    q_entry.address_type = type_r;
    q_entry.emit_prefix  = emit_r;
  end

  always_comb begin
    test_nxt = test_r;
    type_nxt = type_r;
    emit_nxt = emit_r;
    if (cfg_we) begin
      case (cfg_index)
        casha_pkg::REG_TEST_NETWORK: test_nxt = cfg_wdata[0];
        casha_pkg::REG_ADDRESS_TYPE: type_nxt = cfg_wdata;
        casha_pkg::REG_EMIT_PREFIX:  emit_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      cnt_nxt = is_last ? '0 : CW'(cnt_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_r <= 1'b0;
      type_r <= 5'd0;
      emit_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      test_r <= test_nxt;
      type_r <= type_nxt;
      emit_r <= emit_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> rtl/casha_fifo.sv
module casha_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  casha_pkg::entry_t      push_entry,
  input  logic                   pop,
  output casha_pkg::entry_t      head,
  output casha_pkg::fifo_stat_t  stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [AW:0]   FULL_CNT = (AW+1)'(DEPTH);

  casha_pkg::entry_t slots_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);
  assign head       = slots_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == LAST_PTR) ? '0 : AW'(wr_r + 1'b1);
    if (pop)  rd_nxt = (rd_r == LAST_PTR) ? '0 : AW'(rd_r + 1'b1);
    if (push && !pop) cnt_nxt = (AW+1)'(cnt_r + 1'b1);
    else if (pop && !push) cnt_nxt = (AW+1)'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/casha_back.sv
module casha_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  casha_pkg::entry_t     q_head,
  input  casha_pkg::fifo_stat_t q_stat,
  output logic                  q_pop,
  casha_out_if.source           out_ch
);

  casha_pkg::back_state_t st_r, st_nxt;
  casha_pkg::entry_t cur_r, cur_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [3:0]  pend_r, pend_nxt;
  logic [39:0] csum_r, csum_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        need_r, need_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [6:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;

  logic        slot;
  logic [3:0]  pend_m;
  logic        drained;
  logic [4:0]  sym;
  logic [4:0]  pad_sym;
  logic [3:0]  pfx_last;
  logic        idle_pop;
  logic        chain_pop;
  logic [39:0] absorb_c;

  assign slot     = !out_valid_r || out_ch.ready;
  assign pend_m   = 4'(pend_r - 4'd5);
  assign drained  = (pend_m < 4'd5);
  assign sym      = 5'(acc_r >> pend_m);
  assign pad_sym  = 5'(acc_r[4:0] << (3'd5 - pend_r[2:0]));
  assign pfx_last = cur_r.test_network ? casha_pkg::TEST_PFX_LAST : casha_pkg::MAIN_PFX_LAST;
  assign absorb_c = casha_pkg::poly_step(csum_r, 5'd0);

  assign idle_pop  = (st_r == casha_pkg::B_IDLE) && !q_stat.empty;
  // next byte of the same address follows without a trip through idle
  assign chain_pop = (st_r == casha_pkg::B_SYM) && slot && drained && !need_r &&
                     !cur_r.last && !q_stat.empty && !q_head.first;
  assign q_pop     = idle_pop || chain_pop;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.addr_char = out_char_r;
  assign out_ch.last_char = out_last_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      casha_pkg::B_IDLE: begin
        if (idle_pop) begin
          if (q_head.first && q_head.emit_prefix) st_nxt = casha_pkg::B_PREFIX;
          else st_nxt = casha_pkg::B_SYM;
        end
      end
      casha_pkg::B_PREFIX: begin
        if (slot && idx_r == pfx_last) st_nxt = casha_pkg::B_SYM;
      end
      casha_pkg::B_SYM: begin
        if (slot && drained && !need_r) begin
          if (cur_r.last) begin
            st_nxt = (pend_m != 4'd0) ? casha_pkg::B_PAD : casha_pkg::B_ABSORB;
          end else if (!chain_pop) begin
            st_nxt = casha_pkg::B_IDLE;
          end
        end
      end
      casha_pkg::B_PAD: begin
        if (slot) st_nxt = casha_pkg::B_ABSORB;
      end
      casha_pkg::B_ABSORB: begin
        if (idx_r == 4'd7) st_nxt = casha_pkg::B_CSUM;
      end
      casha_pkg::B_CSUM: begin
        if (slot && idx_r == 4'd7) st_nxt = casha_pkg::B_IDLE;
      end
      default: st_nxt = casha_pkg::B_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    cur_nxt  = cur_r;
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    csum_nxt = csum_r;
    idx_nxt  = idx_r;
    need_nxt = need_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (st_r)
      casha_pkg::B_IDLE: begin
        if (idle_pop) begin
          cur_nxt = q_head;
          if (q_head.first) begin
            csum_nxt = q_head.test_network ? casha_pkg::TEST_START : casha_pkg::MAIN_START;
            need_nxt = 1'b1;
            idx_nxt  = 4'd0;
            if (q_head.emit_prefix) begin
              acc_nxt  = 12'd0;
              pend_nxt = 4'd0;
            end else begin
              acc_nxt  = {4'd0, q_head.address_type, 3'b000};
              pend_nxt = 4'd8;
            end
          end else begin
            acc_nxt  = {acc_r[3:0], q_head.payload_byte};
            pend_nxt = 4'(pend_r + 4'd8);
          end
        end
      end
      casha_pkg::B_PREFIX: begin
        if (slot) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = casha_pkg::pfx_char(cur_r.test_network, idx_r);
          out_last_nxt  = 1'b0;
          idx_nxt       = 4'(idx_r + 1'b1);
          if (idx_r == pfx_last) begin
            acc_nxt  = {4'd0, cur_r.address_type, 3'b000};
            pend_nxt = 4'd8;
          end
        end
      end
      casha_pkg::B_SYM: begin
        if (slot) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = casha_pkg::sym_char(sym);
          out_last_nxt  = 1'b0;
          csum_nxt      = casha_pkg::poly_step(csum_r, sym);
          pend_nxt      = pend_m;
          idx_nxt       = 4'd0;
          if (drained && need_r) begin
            // version byte done, bring in the first payload byte
            acc_nxt  = {acc_r[3:0], cur_r.payload_byte};
            pend_nxt = 4'(pend_m + 4'd8);
            need_nxt = 1'b0;
          end else if (chain_pop) begin
            cur_nxt  = q_head;
            acc_nxt  = {acc_r[3:0], q_head.payload_byte};
            pend_nxt = 4'(pend_m + 4'd8);
          end
        end
      end
      casha_pkg::B_PAD: begin
        if (slot) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = casha_pkg::sym_char(pad_sym);
          out_last_nxt  = 1'b0;
          csum_nxt      = casha_pkg::poly_step(csum_r, pad_sym);
          pend_nxt      = 4'd0;
          idx_nxt       = 4'd0;
        end
      end
      casha_pkg::B_ABSORB: begin
        if (idx_r == 4'd7) begin
          csum_nxt = absorb_c ^ 40'd1;
          idx_nxt  = 4'd0;
        end else begin
          csum_nxt = absorb_c;
          idx_nxt  = 4'(idx_r + 1'b1);
        end
      end
      casha_pkg::B_CSUM: begin
        if (slot) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = casha_pkg::sym_char(csum_r[39:35]);
          out_last_nxt  = (idx_r == 4'd7);
          csum_nxt      = {csum_r[34:0], 5'd0};
          idx_nxt       = 4'(idx_r + 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    acc_r      <= acc_nxt;
    csum_r     <= csum_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= casha_pkg::B_IDLE;
      pend_r      <= 4'd0;
      idx_r       <= 4'd0;
      need_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pend_r      <= pend_nxt;
      idx_r       <= idx_nxt;
      need_r      <= need_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/cashaddr_encoder.sv
// Cashaddr encoder: takes the payload hash one byte per item and sends out the
// address as ASCII characters, one per item, with last_char on the final
// checksum character. A front stage counts bytes and tags each byte with the
// register values, which the back takes from the first byte of each address; a
// queue of QUEUE_DEPTH bytes feeds a back sequencer that emits at most one
// character per cycle into an output register while the output is not stalled.
// Input is taken at one byte per cycle while the queue has room. For each
// address the sequencer leaves idle, sends the prefix (12 or 8 characters, or
// none), one character per 5-bit symbol (about 1.6 per byte), absorbs eight zero
// symbols and sends eight checksum characters. A byte that finds the queue empty
// sends the sequencer back through idle.
`include "assert_macros.svh"

module cashaddr_encoder #(
  parameter int PAYLOAD_BYTES = 20,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  casha_in_if.sink   in_ch,
  casha_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_wdata
);

  casha_pkg::entry_t     q_entry;
  casha_pkg::entry_t     q_head;
  casha_pkg::fifo_stat_t q_stat;
  logic                  q_push;
  logic                  q_pop;

  casha_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  casha_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  casha_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .q_head(q_head),
    .q_stat(q_stat),
    .q_pop (q_pop),
    .out_ch(out_ch)
  );

  `CASHA_CHECK(a_no_push_full, clk, rst_n, q_push |-> !q_stat.full, "push into full queue")
  `CASHA_CHECK(a_no_pop_empty, clk, rst_n, q_pop |-> !q_stat.empty, "pop from empty queue")
  `CASHA_CHECK(a_push_fills, clk, rst_n, (q_push && !q_pop) |=> !q_stat.empty, "queue lost an item")
  `CASHA_CHECK(a_ready_tracks, clk, rst_n, in_ch.ready == !q_stat.full, "ready out of step with queue")
  `CASHA_CHECK_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_ch.valid, "output valid after reset")

endmodule
